>>> rtl/mlg_pkg.sv
// mlg_pkg: constants, types and arithmetic helpers for the mercator grid mapper
// used by mercator_latlon_to_grid; no dependencies
package mlg_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int LOG_FRAC     = 40;
  localparam int LOG_BITS     = (CORDIC_STEPS > LOG_FRAC) ? LOG_FRAC : CORDIC_STEPS;
  localparam int CW           = 34;

  localparam logic signed [CW-1:0] CORDIC_ONE       = 34'sd1073741824;
  localparam logic signed [CW-1:0] QUARTER_PI       = 34'sd843314857;
  localparam logic signed [29:0]   LAT_LIMIT        = 30'sd377445417;
  localparam logic signed [34:0]   HALF_RAD_PER_DEG = 35'sd9595049034;
  localparam logic signed [35:0]   TURN             = 36'sd1509949440;
  localparam logic [47:0]          LN2_MAG          = 48'd762123384786;
  localparam logic [96:0]          SAT62            = 97'd4611686018427387904;
  localparam logic signed [63:0]   MAX48            = 64'sd140737488355327;
  localparam logic signed [63:0]   MIN48            = -64'sd140737488355328;

  typedef enum logic [2:0] {
    REG_REF_LON    = 3'd0,
    REG_COL_SCALE  = 3'd1,
    REG_COL_OFFSET = 3'd2,
    REG_ROW_SCALE  = 3'd3,
    REG_ROW_OFFSET = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cord_t;

  typedef struct packed {
    logic               flag;
    logic signed [35:0] u;
  } side_t;

  typedef struct packed {
    logic [30:0]         f;
    logic [5:0]          e;
    logic [LOG_FRAC-1:0] fr;
  } logax_t;

  typedef struct packed {
    logax_t x;
    logax_t y;
  } logv_t;

  typedef struct packed {
    logic [47:0] am;
    logic [47:0] bm;
    logic        neg;
  } mop_t;

  typedef struct packed {
    logic [47:0] p00;
    logic [47:0] p01;
    logic [47:0] p10;
    logic [47:0] p11;
    logic        neg;
  } pp_t;

  typedef struct packed {
    logic [95:0] p;
    logic        neg;
  } prod_t;

  function automatic logic signed [CW-1:0] atan_q30(input int i);
    logic signed [CW-1:0] r;
    case (i)
      0: r = 34'sd843314856;
      1: r = 34'sd497837829;
      2: r = 34'sd263043836;
      3: r = 34'sd133525158;
      4: r = 34'sd67021686;
      5: r = 34'sd33543515;
      6: r = 34'sd16775850;
      7: r = 34'sd8388437;
      8: r = 34'sd4194282;
      9: r = 34'sd2097149;
      default: begin
        if (i < 30) r = (CW'(1) << (30 - i)) - CW'(1);
        else r = '0;
      end
    endcase
    return r;
  endfunction

  function automatic cord_t cord_step(input cord_t c, input int i);
    cord_t r;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] a;
    dx = c.y >>> i;
    dy = c.x >>> i;
    a  = atan_q30(i);
    if (!c.z[CW-1]) begin
      r.x = c.x - dx;
      r.y = c.y + dy;
      r.z = c.z - a;
    end else begin
      r.x = c.x + dx;
      r.y = c.y - dy;
      r.z = c.z + a;
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] clamp_pos(input logic signed [CW-1:0] v);
    return (v <= 0) ? CW'(1) : v;
  endfunction

  function automatic logic [5:0] lead_pos(input logic [CW-1:0] m);
    logic [5:0] e;
    e = '0;
    for (int j = 0; j < CW; j++) begin
      if (m[j]) e = 6'(j);
    end
    return e;
  endfunction

  function automatic logax_t norm_ax(input logic [CW-1:0] m, input logic [5:0] e);
    logax_t r;
    logic [CW+29:0] t;
    t    = {m, 30'd0} >> e;
    r.f  = t[30:0];
    r.e  = e;
    r.fr = '0;
    return r;
  endfunction

  function automatic logax_t sq_step(input logax_t a, input int k);
    logax_t r;
    logic [61:0] p;
    logic [31:0] s;
    r = a;
    p = 62'(a.f) * 62'(a.f);
    s = p[61:30];
    if (s[31]) begin
      r.fr[LOG_FRAC-k] = 1'b1;
      r.f = s[31:1];
    end else begin
      r.f = s[30:0];
    end
    return r;
  endfunction

  function automatic logic [47:0] mag48(input logic signed [47:0] a);
    return a[47] ? 48'(-a) : a;
  endfunction

  function automatic pp_t mul_pp(input mop_t m);
    pp_t r;
    r.p00 = 48'(m.am[23:0])  * 48'(m.bm[23:0]);
    r.p01 = 48'(m.am[23:0])  * 48'(m.bm[47:24]);
    r.p10 = 48'(m.am[47:24]) * 48'(m.bm[23:0]);
    r.p11 = 48'(m.am[47:24]) * 48'(m.bm[47:24]);
    r.neg = m.neg;
    return r;
  endfunction

  function automatic prod_t mul_sum(input pp_t pp);
    prod_t r;
    r.p = {48'd0, pp.p00} + ({48'd0, pp.p01} << 24) + ({48'd0, pp.p10} << 24)
        + {pp.p11, 48'd0};
    r.neg = pp.neg;
    return r;
  endfunction

  function automatic logic signed [63:0] mul_round(input prod_t pr, input int s);
    logic [96:0] t;
    logic [96:0] q;
    t = {1'b0, pr.p} + (97'd1 << (s - 1));
    q = t >> s;
    if (q > SAT62) q = SAT62;
    return pr.neg ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

  function automatic logic [47:0] sat48(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = v;
    if (v > MAX48) r = MAX48;
    if (v < MIN48) r = MIN48;
    return r[47:0];
  endfunction

endpackage

>>> rtl/mercator_latlon_to_grid.sv
// pipeline: CORDIC_STEPS + LOG_BITS + 14 register stages (62 at the default settings),
// with one cordic rotation and one log2 squaring per stage plus split multipliers
// throughput: one point per cycle; a stalled output holds the whole pipeline in place
// reset: synchronous active-low rst_n clears all valid bits and the five registers
// uses mlg_pkg; apb config port, stream input and output
module mercator_latlon_to_grid
  import mlg_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,     // lat_deg[29:0], lon_deg[61:30], zero fill
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,    // grid_col[47:0], grid_row[95:48]
  output logic         out_tuser,    // pole_clamped
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [5:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic signed [32:0] ref_lon_r;
  logic signed [47:0] col_scale_r, col_offset_r, row_scale_r, row_offset_r;

  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_lon_r    <= '0;
      col_scale_r  <= '0;
      col_offset_r <= '0;
      row_scale_r  <= '0;
      row_offset_r <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(cfg_paddr[5:3]))
        REG_REF_LON:    ref_lon_r    <= cfg_pwdata[32:0];
        REG_COL_SCALE:  col_scale_r  <= cfg_pwdata[47:0];
        REG_COL_OFFSET: col_offset_r <= cfg_pwdata[47:0];
        REG_ROW_SCALE:  row_scale_r  <= cfg_pwdata[47:0];
        REG_ROW_OFFSET: row_offset_r <= cfg_pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(cfg_paddr[5:3]))
      REG_REF_LON:    cfg_prdata = 64'(ref_lon_r);
      REG_COL_SCALE:  cfg_prdata = 64'(col_scale_r);
      REG_COL_OFFSET: cfg_prdata = 64'(col_offset_r);
      REG_ROW_SCALE:  cfg_prdata = 64'(row_scale_r);
      REG_ROW_OFFSET: cfg_prdata = 64'(row_offset_r);
      default:        cfg_prdata = '0;
    endcase
  end

  logic en;
  logic out_vld_r;
  assign en        = out_tready | ~out_vld_r;
  assign in_tready = en;
  assign out_tvalid = out_vld_r;

  // stage a: pole clamp and window offset
  logic signed [29:0] lat_in, lat_c;
  logic signed [31:0] lon_in;
  logic               flag_in;
  assign lat_in = in_tdata[29:0];
  assign lon_in = in_tdata[61:30];

  always_comb begin
    lat_c   = lat_in;
    flag_in = 1'b0;
    if (lat_in > LAT_LIMIT) begin
      lat_c   = LAT_LIMIT;
      flag_in = 1'b1;
    end
    if (lat_in < -LAT_LIMIT) begin
      lat_c   = -LAT_LIMIT;
      flag_in = 1'b1;
    end
  end

  logic               a_vld_r, a_flag_r;
  logic signed [29:0] a_lat_r;
  logic signed [31:0] a_lon_r;
  logic signed [33:0] a_d_r;

  // stage b: angle and whole turns
  logic signed [64:0]   th_prod;
  logic signed [CW-1:0] theta_nxt;
  logic [3:0]           turn_cnt;
  logic                 b_vld_r, b_flag_r;
  logic signed [CW-1:0] b_theta_r;
  logic signed [3:0]    b_q_r;
  logic signed [31:0]   b_lon_r;

  always_comb begin
    th_prod   = 65'(a_lat_r) * 65'(HALF_RAD_PER_DEG);
    theta_nxt = QUARTER_PI + CW'((th_prod + 65'sd2147483648) >>> 32);
    turn_cnt  = '0;
    for (int k = -4; k <= 4; k++) begin
      if (36'(a_d_r) >= 36'(k) * TURN) turn_cnt = turn_cnt + 4'd1;
    end
  end

  // cordic rotation, one iteration per stage
  cord_t cr_r [CORDIC_STEPS];
  side_t cs_r [CORDIC_STEPS];
  logic [CORDIC_STEPS-1:0] cv_r;
  cord_t cr_nxt [CORDIC_STEPS];
  cord_t c0;
  side_t s0;

  always_comb begin
    c0.x   = CORDIC_ONE;
    c0.y   = '0;
    c0.z   = b_theta_r;
    s0.flag = b_flag_r;
    s0.u   = -(36'(b_lon_r) - 36'(b_q_r) * TURN);
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (i == 0) cr_nxt[i] = cord_step(c0, i);
      else cr_nxt[i] = cord_step(cr_r[i-1], i);
    end
  end

  // log2: leading one, then normalise and square
  logic [CW-1:0] mx_c, my_c;
  assign mx_c = clamp_pos(cr_r[CORDIC_STEPS-1].x);
  assign my_c = clamp_pos(cr_r[CORDIC_STEPS-1].y);

  logic          l0_vld_r;
  logic [CW-1:0] l0_mx_r, l0_my_r;
  logic [5:0]    l0_ex_r, l0_ey_r;
  side_t         l0_side_r;

  logv_t lg_r   [LOG_BITS+1];
  side_t ls_r   [LOG_BITS+1];
  logic [LOG_BITS:0] lv_r;
  logv_t lg_nxt [LOG_BITS+1];

  always_comb begin
    lg_nxt[0].x = norm_ax(l0_mx_r, l0_ex_r);
    lg_nxt[0].y = norm_ax(l0_my_r, l0_ey_r);
    for (int k = 1; k <= LOG_BITS; k++) begin
      lg_nxt[k].x = sq_step(lg_r[k-1].x, k);
      lg_nxt[k].y = sq_step(lg_r[k-1].y, k);
    end
  end

  // log difference times ln2
  logic               d_vld_r;
  logic signed [47:0] d_diff_r;
  side_t              d_side_r;
  logic               m1_vld_r, m2_vld_r, m3_vld_r, m4_vld_r;
  mop_t               m1_r;
  pp_t                m2_r;
  prod_t              m3_r;
  logic signed [47:0] m4_v_r;
  side_t              m1_side_r, m2_side_r, m3_side_r, m4_side_r;
  logic signed [63:0] v_nxt;
  assign v_nxt = mul_round(m3_r, 48);

  // final scale and offset on both axes
  logic               r1_vld_r, r2_vld_r, r3_vld_r, r4_vld_r;
  logic               r1_flag_r, r2_flag_r, r3_flag_r, r4_flag_r;
  mop_t               r1_row_r, r1_col_r;
  pp_t                r2_row_r, r2_col_r;
  prod_t              r3_row_r, r3_col_r;
  logic signed [63:0] r4_row_r, r4_col_r;
  logic signed [47:0] u48;
  logic signed [63:0] row_p_nxt, col_p_nxt;
  logic [47:0]        out_col_r, out_row_r;
  logic               out_flag_r;

  assign u48       = 48'(m4_side_r.u);
  assign row_p_nxt = mul_round(r3_row_r, 48);
  assign col_p_nxt = mul_round(r3_col_r, 38);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      cv_r      <= '0;
      l0_vld_r  <= 1'b0;
      lv_r      <= '0;
      d_vld_r   <= 1'b0;
      m1_vld_r  <= 1'b0;
      m2_vld_r  <= 1'b0;
      m3_vld_r  <= 1'b0;
      m4_vld_r  <= 1'b0;
      r1_vld_r  <= 1'b0;
      r2_vld_r  <= 1'b0;
      r3_vld_r  <= 1'b0;
      r4_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r   <= in_tvalid;
      b_vld_r   <= a_vld_r;
      cv_r      <= {cv_r[CORDIC_STEPS-2:0], b_vld_r};
      l0_vld_r  <= cv_r[CORDIC_STEPS-1];
      lv_r      <= {lv_r[LOG_BITS-1:0], l0_vld_r};
      d_vld_r   <= lv_r[LOG_BITS];
      m1_vld_r  <= d_vld_r;
      m2_vld_r  <= m1_vld_r;
      m3_vld_r  <= m2_vld_r;
      m4_vld_r  <= m3_vld_r;
      r1_vld_r  <= m4_vld_r;
      r2_vld_r  <= r1_vld_r;
      r3_vld_r  <= r2_vld_r;
      r4_vld_r  <= r3_vld_r;
      out_vld_r <= r4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_lat_r  <= lat_c;
      a_flag_r <= flag_in;
      a_lon_r  <= lon_in;
      a_d_r    <= 34'(lon_in) - 34'(ref_lon_r);

      b_theta_r <= theta_nxt;
      b_q_r     <= $signed(turn_cnt - 4'd5);
      b_lon_r   <= a_lon_r;
      b_flag_r  <= a_flag_r;

      for (int i = 0; i < CORDIC_STEPS; i++) begin
        cr_r[i] <= cr_nxt[i];
        if (i == 0) cs_r[i] <= s0;
        else cs_r[i] <= cs_r[i-1];
      end

      l0_mx_r   <= mx_c;
      l0_my_r   <= my_c;
      l0_ex_r   <= lead_pos(mx_c);
      l0_ey_r   <= lead_pos(my_c);
      l0_side_r <= cs_r[CORDIC_STEPS-1];

      for (int k = 0; k <= LOG_BITS; k++) begin
        lg_r[k] <= lg_nxt[k];
        if (k == 0) ls_r[k] <= l0_side_r;
        else ls_r[k] <= ls_r[k-1];
      end

      d_diff_r <= $signed({2'b00, lg_r[LOG_BITS].y.e, lg_r[LOG_BITS].y.fr})
                - $signed({2'b00, lg_r[LOG_BITS].x.e, lg_r[LOG_BITS].x.fr});
      d_side_r <= ls_r[LOG_BITS];

      m1_r.am   <= mag48(d_diff_r);
      m1_r.bm   <= LN2_MAG;
      m1_r.neg  <= d_diff_r[47];
      m1_side_r <= d_side_r;
      m2_r      <= mul_pp(m1_r);
      m2_side_r <= m1_side_r;
      m3_r      <= mul_sum(m2_r);
      m3_side_r <= m2_side_r;
      m4_v_r    <= v_nxt[47:0];
      m4_side_r <= m3_side_r;

      r1_row_r.am  <= mag48(m4_v_r);
      r1_row_r.bm  <= mag48(row_scale_r);
      r1_row_r.neg <= m4_v_r[47] ^ row_scale_r[47];
      r1_col_r.am  <= mag48(u48);
      r1_col_r.bm  <= mag48(col_scale_r);
      r1_col_r.neg <= u48[47] ^ col_scale_r[47];
      r1_flag_r    <= m4_side_r.flag;

      r2_row_r  <= mul_pp(r1_row_r);
      r2_col_r  <= mul_pp(r1_col_r);
      r2_flag_r <= r1_flag_r;
      r3_row_r  <= mul_sum(r2_row_r);
      r3_col_r  <= mul_sum(r2_col_r);
      r3_flag_r <= r2_flag_r;
      r4_row_r  <= row_p_nxt;
      r4_col_r  <= col_p_nxt;
      r4_flag_r <= r3_flag_r;

      out_col_r  <= sat48(r4_col_r + 64'(col_offset_r));
      out_row_r  <= sat48(r4_row_r + 64'(row_offset_r));
      out_flag_r <= r4_flag_r;
    end
  end

  assign out_tdata = {out_row_r, out_col_r};
  assign out_tuser = out_flag_r;

`ifndef SYNTHESIS
  a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
    a_vld_r && a_flag_r |-> (a_lat_r == LAT_LIMIT || a_lat_r == -LAT_LIMIT))
    else $error("pole flag without clamped latitude");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> a_vld_r)
    else $error("accepted transfer did not enter the pipeline");

  a_wrap_window: assert property (@(posedge clk) disable iff (!rst_n)
    cv_r[0] |-> ((-cs_r[0].u) >= 36'(ref_lon_r) && (-cs_r[0].u) < 36'(ref_lon_r) + TURN))
    else $error("wrapped longitude outside window");

  a_log_norm: assert property (@(posedge clk) disable iff (!rst_n)
    lv_r[0] |-> (lg_r[0].x.f[30] && lg_r[0].y.f[30]))
    else $error("log mantissa not normalised");
`endif

endmodule
